### rtl/tsfr_pkg.sv
// Shared types and constants for the timed serial frame receiver.
// Used by the configuration, core and top-level files; depends on nothing.
package tsfr_pkg;

    // Register widths and reset values
    localparam int BIT_PERIOD_W = 12;
    localparam int HOLDOFF_W    = 16;
    localparam int CFG_DATA_W   = 16;
    localparam int CFG_INDEX_W  = 1;
    localparam int COUNT_W      = 32;
    // 3q + holdoff reaches 68604, so the timer needs 17 bits
    localparam int TIMER_W      = 17;

    localparam logic [BIT_PERIOD_W-1:0] BIT_PERIOD_RESET = 12'd50;
    localparam logic [HOLDOFF_W-1:0]    HOLDOFF_RESET    = 16'd5000;

    // Register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] CFG_BIT_PERIOD = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HOLDOFF    = 1'b1;

    // Receiver phases, one-hot
    typedef enum logic [3:0] {
        PH_LISTEN = 4'b0001,
        PH_MODE   = 4'b0010,
        PH_DATA   = 4'b0100,
        PH_HOLD   = 4'b1000
    } tsfr_phase_t;

    // Live configuration handed to the core
    typedef struct packed {
        logic [BIT_PERIOD_W-1:0] bit_period;
        logic [HOLDOFF_W-1:0]    holdoff_ticks;
    } tsfr_cfg_t;

    // A wait of zero ticks is stretched to one tick
    function automatic logic [TIMER_W-1:0] min_one(input logic [TIMER_W-1:0] v);
        logic [TIMER_W-1:0] r;
        r = (v == '0) ? TIMER_W'(1) : v;
        return r;
    endfunction

endpackage

### rtl/tsfr_if.sv
// Handshake channels of the timed serial frame receiver: tick input and frame output.
// Depends on nothing; the frame width follows the DATA_BITS parameter.
interface tsfr_tick_if;
    logic valid;
    logic ready;
    logic line_level;

    modport source (output valid, output line_level, input ready);
    modport sink   (input valid, input line_level, output ready);
endinterface

interface tsfr_frame_if #(
    parameter int DATA_BITS = 12
);
    logic                 valid;
    logic                 ready;
    logic [DATA_BITS-1:0] frame_value;
    logic                 frame_mode;
    logic [31:0]          frame_count;
    logic                 count_mismatch;

    modport source (output valid, output frame_value, output frame_mode,
                    output frame_count, output count_mismatch, input ready);
    modport sink   (input valid, input frame_value, input frame_mode,
                    input frame_count, input count_mismatch, output ready);
endinterface

### rtl/tsfr_cfg.sv
// Configuration registers of the timed serial frame receiver.
// Depends on tsfr_pkg for widths, indexes and reset values.
module tsfr_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [tsfr_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [tsfr_pkg::CFG_DATA_W-1:0]     cfg_data,
    output tsfr_pkg::tsfr_cfg_t                 cfg
);

    logic [tsfr_pkg::BIT_PERIOD_W-1:0] bit_period_reg;
    logic [tsfr_pkg::HOLDOFF_W-1:0]    holdoff_reg;

    // Take register writes by index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_period_reg <= tsfr_pkg::BIT_PERIOD_RESET;
            holdoff_reg    <= tsfr_pkg::HOLDOFF_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                tsfr_pkg::CFG_BIT_PERIOD:
                    bit_period_reg <= cfg_data[tsfr_pkg::BIT_PERIOD_W-1:0];
                tsfr_pkg::CFG_HOLDOFF:
                    holdoff_reg <= cfg_data[tsfr_pkg::HOLDOFF_W-1:0];
                default:
                    ;
            endcase
        end
    end

    assign cfg.bit_period    = bit_period_reg;
    assign cfg.holdoff_ticks = holdoff_reg;

endmodule

### rtl/tsfr_core.sv
// Frame timing, bit sampling and frame counter of the timed serial frame receiver.
// Depends on tsfr_pkg; state advances by one tick whenever step is high.
module tsfr_core #(
    parameter int DATA_BITS = 12
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tsfr_pkg::tsfr_cfg_t           cfg,
    input  logic                          step,
    input  logic                          line,
    output logic                          res_valid,
    output logic [DATA_BITS-1:0]          res_value,
    output logic                          res_mode,
    output logic [tsfr_pkg::COUNT_W-1:0]  res_count,
    output logic                          res_mismatch
);

    localparam int BIT_IDX_W = $clog2(DATA_BITS + 1);
    localparam int TW        = tsfr_pkg::TIMER_W;

    tsfr_pkg::tsfr_phase_t            phase_reg, phase_next;
    logic [TW-1:0]                    timer_reg, timer_next;
    logic [BIT_IDX_W-1:0]             bidx_reg, bidx_next, bidx_inc;
    logic [DATA_BITS-1:0]             shift_reg, shift_next, shifted;
    logic                             mode_reg, mode_next;
    logic [tsfr_pkg::COUNT_W-1:0]     count_reg, count_next;

    logic [9:0]                       quarter;
    logic [TW-1:0]                    load_mode, load_bit, load_hold;
    logic [11:0]                      three_q;
    logic                             tick_due;

    // Timer reload values from the live configuration
    assign quarter   = cfg.bit_period[tsfr_pkg::BIT_PERIOD_W-1:2];
    assign three_q   = {1'b0, quarter, 1'b0} + {2'b00, quarter};
    assign load_mode = tsfr_pkg::min_one(TW'(cfg.bit_period) + TW'(quarter));
    assign load_bit  = tsfr_pkg::min_one(TW'({quarter, 2'b00}));
    assign load_hold = tsfr_pkg::min_one(TW'(three_q) + TW'(cfg.holdoff_ticks));

    assign tick_due = (phase_reg != tsfr_pkg::PH_LISTEN) && (timer_reg <= TW'(1));
    assign shifted  = (shift_reg << 1) | DATA_BITS'(line);
    assign bidx_inc = bidx_reg + BIT_IDX_W'(1);

    // Next state for one tick
    always_comb
    begin
        phase_next   = phase_reg;
        timer_next   = timer_reg;
        bidx_next    = bidx_reg;
        shift_next   = shift_reg;
        mode_next    = mode_reg;
        count_next   = count_reg;
        res_valid    = 1'b0;
        res_mismatch = 1'b0;

        // Count down a running wait
        if (phase_reg != tsfr_pkg::PH_LISTEN && !tick_due)
        begin
            timer_next = timer_reg - TW'(1);
        end

        // Act on the tick at which a wait runs out
        if (tick_due)
        begin
            case (phase_reg)
                tsfr_pkg::PH_MODE:
                begin
                    mode_next  = line;
                    shift_next = '0;
                    bidx_next  = '0;
                    timer_next = load_bit;
                    phase_next = tsfr_pkg::PH_DATA;
                end
                tsfr_pkg::PH_DATA:
                begin
                    shift_next = shifted;
                    bidx_next  = bidx_inc;
                    if (bidx_inc >= BIT_IDX_W'(DATA_BITS))
                    begin
                        res_valid = 1'b1;
                        if (!mode_reg)
                        begin
                            count_next = count_reg + tsfr_pkg::COUNT_W'(1);
                        end
                        else
                        begin
                            res_mismatch = (count_reg != tsfr_pkg::COUNT_W'(shifted));
                            count_next   = tsfr_pkg::COUNT_W'(shifted);
                        end
                        timer_next = load_hold;
                        phase_next = tsfr_pkg::PH_HOLD;
                    end
                    else
                    begin
                        timer_next = load_bit;
                    end
                end
                default:
                begin
                    phase_next = tsfr_pkg::PH_LISTEN;
                    timer_next = '0;
                end
            endcase
        end

        // Start a frame on a high level while listening
        if (phase_next == tsfr_pkg::PH_LISTEN && line)
        begin
            timer_next = load_mode;
            bidx_next  = '0;
            shift_next = '0;
            phase_next = tsfr_pkg::PH_MODE;
        end
    end

    assign res_value = shifted;
    assign res_mode  = mode_reg;
    assign res_count = count_next;

    // Advance state on each processed tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= tsfr_pkg::PH_LISTEN;
            timer_reg <= '0;
            bidx_reg  <= '0;
            shift_reg <= '0;
            mode_reg  <= 1'b0;
            count_reg <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            timer_reg <= timer_next;
            bidx_reg  <= bidx_next;
            shift_reg <= shift_next;
            mode_reg  <= mode_next;
            count_reg <= count_next;
        end
    end

endmodule

### rtl/timed_serial_frame_receiver.sv
// Top level of the timed serial frame receiver: tick register, core and result register.
// Depends on tsfr_pkg, tsfr_if, tsfr_cfg and tsfr_core.
//
//   channel  | direction | payload
//   ---------+-----------+-------------------------------------------------------
//   tick     | in        | line_level
//   frame    | out       | frame_value, frame_mode, frame_count, count_mismatch
//   cfg      | in        | cfg_write, cfg_index, cfg_data (write only)
//
// One tick is taken per cycle unless a frame-completing tick waits on a held result. A
// tick passes from the tick register through the combinational core into the result
// register, which offers a frame once its last data tick is processed. Reset puts the
// receiver in the listening phase with the frame counter at zero. A held result stalls
// only a tick that itself completes a frame; other ticks keep flowing behind it.
module timed_serial_frame_receiver #(
    parameter int DATA_BITS = 12
) (
    input  logic                               clk,
    input  logic                               rst_n,
    tsfr_tick_if.sink                          tick,
    tsfr_frame_if.source                       frame,
    input  logic                               cfg_write,
    input  logic [tsfr_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [tsfr_pkg::CFG_DATA_W-1:0]    cfg_data
);

    tsfr_pkg::tsfr_cfg_t          cfg;

    logic                         in_valid_reg, in_valid_next;
    logic                         line_reg;
    logic                         step;

    logic                         res_valid;
    logic [DATA_BITS-1:0]         res_value;
    logic                         res_mode;
    logic [tsfr_pkg::COUNT_W-1:0] res_count;
    logic                         res_mismatch;

    logic                         out_valid_reg, out_valid_next;
    logic [DATA_BITS-1:0]         value_reg;
    logic                         mode_reg;
    logic [tsfr_pkg::COUNT_W-1:0] count_reg;
    logic                         mismatch_reg;
    logic                         out_load;

    tsfr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tsfr_core #(
        .DATA_BITS (DATA_BITS)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .step         (step),
        .line         (line_reg),
        .res_valid    (res_valid),
        .res_value    (res_value),
        .res_mode     (res_mode),
        .res_count    (res_count),
        .res_mismatch (res_mismatch)
    );

    // Process the held tick unless its result has nowhere to go
    assign step     = in_valid_reg && (!res_valid || !out_valid_reg || frame.ready);
    assign out_load = step && res_valid;

    assign tick.ready = !in_valid_reg || step;

    // Tick register
    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (tick.valid && tick.ready)
        begin
            in_valid_next = 1'b1;
        end
        else if (step)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick.valid && tick.ready)
        begin
            line_reg <= tick.line_level;
        end
    end

    // Result register: load a finished frame, drop it once transferred
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (frame.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            value_reg    <= res_value;
            mode_reg     <= res_mode;
            count_reg    <= res_count;
            mismatch_reg <= res_mismatch;
        end
    end

    assign frame.valid          = out_valid_reg;
    assign frame.frame_value    = value_reg;
    assign frame.frame_mode     = mode_reg;
    assign frame.frame_count    = count_reg;
    assign frame.count_mismatch = mismatch_reg;

`ifndef SYNTH
    // A new frame never overwrites one still waiting to be taken
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || frame.ready))
        else $error("result register overwritten");

    // A finished frame is offered on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid_reg)
        else $error("finished frame not offered");

    // A counted frame never reports a mismatch
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && !res_mode) |-> !res_mismatch)
        else $error("mismatch flagged on a counted frame");

    // Ticks are only taken into an empty or draining tick register
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !step) |-> !tick.ready)
        else $error("tick register overrun");
`endif

endmodule
